/* hdl/swmm_pkg.sv */
// ----------------------------------------------------------------------------
// swmm_pkg
// shared constants, field widths and a helper function of the window filter
// ----------------------------------------------------------------------------
package swmm_pkg;

    // default configuration
    localparam int WINDOW_DEF      = 8;
    localparam int CHANNELS_DEF    = 3;
    localparam int SAMPLE_BITS_DEF = 10;

    // transaction field widths
    localparam int CH_FW       = 2;
    localparam int SMP_FW      = 10;
    localparam int MEAN_FW     = 10;
    localparam int MED_FW      = 10;
    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = CH_FW;
    localparam int OUT_TDATA_W = 24;

    // floor of log2, used at elaboration only
    function automatic int floor_log2(input int v);
        int r;
        int x;
        r = 0;
        x = v;
        while (x > 1) begin
            x = x >> 1;
            r = r + 1;
        end
        return r;
    endfunction

endpackage

/* hdl/sliding_window_mean_median_top.sv */
// ----------------------------------------------------------------------------
// sliding_window_mean_median_top
// moving-window mean and median filter for several sensor channels
// ----------------------------------------------------------------------------
// Each input transaction carries a sample in tdata and a channel number in
// tuser. The sample is shifted into that channel's window of the last WINDOW
// samples and one output transaction returns the window mean (sum shifted
// right by floor(log2(WINDOW)), saturated to the sample range) and the window
// median (floor of the average of the two middle sorted values). A channel at
// or above CHANNELS changes no window and returns zeros. After an accepted
// sample the window is streamed, one entry per cycle, through a chain of
// WINDOW insertion-sort cells while an accumulator sums it; the input is not
// ready again until the chain has settled and the result has been loaded into
// the output register, so the time from acceptance to the next possible
// acceptance is set by the length of the sort chain. An out-of-range channel
// skips the sort run. The input is taken while a finished result still waits
// in the output register. Windows reset to zero.
// ----------------------------------------------------------------------------
module sliding_window_mean_median_top
    import swmm_pkg::*;
#(
    parameter int WINDOW      = WINDOW_DEF,
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input stream
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // [9:0] sample
    input  logic [IN_TUSER_W-1:0]  i_s_tuser,   // [1:0] channel
    // result stream
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata    // [9:0] window_mean, [19:10] window_median
);

    localparam int IDX_W    = $clog2(WINDOW);
    localparam int CNT_W    = $clog2(2 * WINDOW);
    localparam int SUM_W    = SAMPLE_BITS + $clog2(WINDOW);
    localparam int SHIFT    = floor_log2(WINDOW);
    localparam int SMP_MASK = (1 << SAMPLE_BITS) - 1;
    localparam int MID      = WINDOW / 2;

    // state codes
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]             r_state, n_state;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [CH_FW-1:0]       r_ch, n_ch;
    logic                   r_zero, n_zero;
    logic [SUM_W-1:0]       r_sum, n_sum;
    logic                   r_out_vld, n_out_vld;
    logic [MEAN_FW-1:0]     r_out_mean, n_out_mean;
    logic [MED_FW-1:0]      r_out_med, n_out_med;

    // input decode
    logic                   w_accept;
    logic [CH_FW-1:0]       w_ch;
    logic [SMP_FW-1:0]      w_smp_field;
    logic [31:0]            w_smp_wide;
    logic [SAMPLE_BITS-1:0] w_sample;
    logic                   w_in_range;

    // feed from the window store into the sort chain
    logic                   w_feed;
    logic [SAMPLE_BITS-1:0] w_feed_data;

    // sort chain links and cell contents
    logic                   w_lnk_vld  [WINDOW+1];
    logic [SAMPLE_BITS-1:0] w_lnk_data [WINDOW+1];
    logic                   w_cell_full [WINDOW];
    logic [SAMPLE_BITS-1:0] w_cell_val  [WINDOW];

    // result arithmetic
    logic [SUM_W-1:0]       w_mean_sh;
    logic [SUM_W-1:0]       w_mean_sat;
    logic [31:0]            w_mean_wide;
    logic [SAMPLE_BITS:0]   w_med_sum;
    logic [31:0]            w_med_wide;
    logic                   w_out_free;

    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_ch        = i_s_tuser[CH_FW-1:0];
    assign w_smp_field = i_s_tdata[SMP_FW-1:0];
    assign w_smp_wide  = 32'(w_smp_field);
    assign w_sample    = w_smp_wide[SAMPLE_BITS-1:0];
    assign w_in_range  = 32'(w_ch) < CHANNELS;

    // feed runs while the run counter of the run phase is below WINDOW
    assign w_feed = (r_state == ST_RUN) && (32'(r_cnt) < WINDOW);

    swmm_window #(
        .WINDOW      (WINDOW),
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (w_accept && w_in_range),
        .i_wr_ch     (w_ch),
        .i_wr_sample (w_sample),
        .i_rd_ch     (r_ch),
        .i_rd_idx    (r_cnt[IDX_W-1:0]),
        .o_rd_data   (w_feed_data)
    );

    // insertion-sort chain: cell k ends up with the k-th smallest value
    assign w_lnk_vld[0]  = w_feed;
    assign w_lnk_data[0] = w_feed_data;

    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        swmm_sort_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clr   (w_accept),
            .i_vld   (w_lnk_vld[g]),
            .i_data  (w_lnk_data[g]),
            .o_vld   (w_lnk_vld[g+1]),
            .o_data  (w_lnk_data[g+1]),
            .o_full  (w_cell_full[g]),
            .o_val   (w_cell_val[g])
        );
    end

    // mean: shift, then clamp for window sizes that are not a power of two
    assign w_mean_sh   = r_sum >> SHIFT;
    assign w_mean_sat  = (w_mean_sh > SUM_W'(SMP_MASK)) ? SUM_W'(SMP_MASK) : w_mean_sh;
    assign w_mean_wide = 32'(w_mean_sat);

    // median from the two middle cells
    assign w_med_sum  = {1'b0, w_cell_val[MID-1]} + {1'b0, w_cell_val[MID]};
    assign w_med_wide = 32'(w_med_sum[SAMPLE_BITS:1]);

    assign w_out_free = !r_out_vld || i_m_tready;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_ch       = r_ch;
        n_zero     = r_zero;
        n_sum      = r_sum;
        n_out_vld  = r_out_vld;
        n_out_mean = r_out_mean;
        n_out_med  = r_out_med;

        if (r_out_vld && i_m_tready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_ch   = w_ch;
                    n_zero = !w_in_range;
                    n_cnt  = '0;
                    n_sum  = '0;
                    // out-of-range channel skips the sort run
                    n_state = w_in_range ? ST_RUN : ST_DONE;
                end
            end
            ST_RUN: begin
                if (w_feed) begin
                    n_sum = r_sum + SUM_W'(w_feed_data);
                end
                n_cnt = r_cnt + 1'b1;
                if (32'(r_cnt) == 2 * WINDOW - 1) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_mean = r_zero ? '0 : w_mean_wide[MEAN_FW-1:0];
                    n_out_med  = r_zero ? '0 : w_med_wide[MED_FW-1:0];
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_out_vld <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_ch       <= n_ch;
        r_zero     <= n_zero;
        r_sum      <= n_sum;
        r_out_mean <= n_out_mean;
        r_out_med  <= n_out_med;
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {(OUT_TDATA_W - MEAN_FW - MED_FW)'(0), r_out_med, r_out_mean};

`ifndef SYNTH
    // the chain holds exactly one window, so nothing ever leaves the last cell
    a_chain_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_lnk_vld[WINDOW])
        else $error("sort chain overflow");

    // after the run every cell has taken a value
    for (genvar a = 0; a < WINDOW; a++) begin : g_chk_full
        a_cell_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (r_state == ST_DONE) && !r_zero |-> w_cell_full[a])
            else $error("sort cell empty at end of run");
    end

    // cells are in ascending order when the result is taken
    for (genvar a = 0; a < WINDOW - 1; a++) begin : g_chk_order
        a_cell_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (r_state == ST_DONE) && !r_zero |-> w_cell_val[a] <= w_cell_val[a+1])
            else $error("sort chain out of order");
    end

    // an in-range sample keeps the input blocked at the start of the run
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_in_range |=> !o_s_tready ##1 !o_s_tready)
        else $error("input taken during sort run");
`endif

endmodule

/* hdl/swmm_window.sv */
// ----------------------------------------------------------------------------
// swmm_window
// per-channel sample windows, shifted on write and read one entry at a time
// ----------------------------------------------------------------------------
module swmm_window
    import swmm_pkg::*;
#(
    parameter int WINDOW      = WINDOW_DEF,
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int IDX_W      = $clog2(WINDOW)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_wr,
    input  logic [CH_FW-1:0]       i_wr_ch,
    input  logic [SAMPLE_BITS-1:0] i_wr_sample,
    input  logic [CH_FW-1:0]       i_rd_ch,
    input  logic [IDX_W-1:0]       i_rd_idx,
    output logic [SAMPLE_BITS-1:0] o_rd_data
);

    logic [SAMPLE_BITS-1:0] r_win [CHANNELS][WINDOW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                for (int i = 0; i < WINDOW; i++) begin
                    r_win[c][i] <= '0;
                end
            end
        end else if (i_wr) begin
            for (int c = 0; c < CHANNELS; c++) begin
                if (32'(i_wr_ch) == c) begin
                    // oldest entry drops out at index zero
                    for (int i = 0; i < WINDOW - 1; i++) begin
                        r_win[c][i] <= r_win[c][i+1];
                    end
                    r_win[c][WINDOW-1] <= i_wr_sample;
                end
            end
        end
    end

    always_comb begin
        o_rd_data = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            if (32'(i_rd_ch) == c) begin
                o_rd_data = r_win[c][i_rd_idx];
            end
        end
    end

endmodule

/* hdl/swmm_sort_cell.sv */
// ----------------------------------------------------------------------------
// swmm_sort_cell
// one insertion-sort cell: keeps the smaller value, passes the larger one on
// ----------------------------------------------------------------------------
module swmm_sort_cell
    import swmm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_clr,
    input  logic                   i_vld,
    input  logic [SAMPLE_BITS-1:0] i_data,
    output logic                   o_vld,
    output logic [SAMPLE_BITS-1:0] o_data,
    output logic                   o_full,
    output logic [SAMPLE_BITS-1:0] o_val
);

    logic                   r_full;
    logic                   r_vld;
    logic [SAMPLE_BITS-1:0] r_val;
    logic [SAMPLE_BITS-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_vld  <= 1'b0;
        end else if (i_clr) begin
            r_full <= 1'b0;
            r_vld  <= 1'b0;
        end else begin
            r_vld <= i_vld && r_full;
            if (i_vld) begin
                r_full <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            if (!r_full) begin
                r_val <= i_data;
            end else if (i_data < r_val) begin
                r_val  <= i_data;
                r_data <= r_val;
            end else begin
                r_data <= i_data;
            end
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;
    assign o_full = r_full;
    assign o_val  = r_val;

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the moving-window mean and median filter
// ----------------------------------------------------------------------------
// Sample transactions are queued by an initial block and driven at the falling
// edge. Each accepted transaction updates a local copy of the channel windows,
// and that copy yields the expected mean and median. The result monitor takes
// every accepted result transaction at the rising edge and checks it against
// the oldest expected one. Both sides idle in random bursts, except in the
// tail of the run.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import swmm_pkg::*;

    localparam int MEAN_SHIFT   = floor_log2(WINDOW_DEF);
    localparam int SAMPLE_MAX   = (1 << SAMPLE_BITS_DEF) - 1;
    localparam int RANDOM_ITEMS = 1400;
    localparam int TAIL_ITEMS   = 120;
    localparam int SETTLE_CYC   = 2 * WINDOW_DEF + 8;

    // one queued sample transaction, or a marker that holds the sender back
    // until every expected result has come in
    typedef struct {
        bit                drain;
        logic [CH_FW-1:0]  channel;
        logic [SMP_FW-1:0] sample;
    } t_sample_item;

    typedef struct packed {
        logic [MED_FW-1:0]  median;
        logic [MEAN_FW-1:0] mean;
    } t_window_stats;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [IN_TUSER_W-1:0]  s_tuser = '0;
    logic                   o_m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    t_sample_item  pend_q[$];
    t_window_stats stats_due[$];

    // local copy of every channel window, oldest entry first
    logic [SMP_FW-1:0] win_hist [CHANNELS_DEF][WINDOW_DEF];

    int unsigned total_items = 0;
    int unsigned accept_count = 0;
    int unsigned result_count = 0;
    int unsigned err_count = 0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned drv_seen = 0;

    sliding_window_mean_median_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),      // [9:0] sample
        .i_s_tuser  (s_tuser),      // [1:0] channel
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata)     // [9:0] window_mean, [19:10] window_median
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // run guard, far above the slowest correct run
    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t, result %0d: %s", $realtime, result_count, what);
        err_count++;
    endtask

    task automatic add_sample(input int ch, input int smp);
        t_sample_item it;
        it.drain   = 1'b0;
        it.channel = ch[CH_FW-1:0];
        it.sample  = smp[SMP_FW-1:0];
        pend_q.push_back(it);
        total_items++;
    endtask

    task automatic add_drain();
        t_sample_item it;
        it.drain   = 1'b1;
        it.channel = '0;
        it.sample  = '0;
        pend_q.push_back(it);
    endtask

    // shift the sample into its channel window, then take mean and median
    function automatic t_window_stats predict_window_stats(
        input logic [CH_FW-1:0]  ch,
        input logic [SMP_FW-1:0] smp
    );
        logic [SMP_FW-1:0] sorted [WINDOW_DEF];
        logic [SMP_FW-1:0] key;
        int unsigned       total;
        int unsigned       mid_sum;
        int                j;
        t_window_stats     r;
        r = '0;
        // channel past the last window: nothing moves, zeros come back
        if (ch >= CHANNELS_DEF)
            return r;
        for (int i = 0; i < WINDOW_DEF - 1; i++)
            win_hist[ch][i] = win_hist[ch][i + 1];
        win_hist[ch][WINDOW_DEF - 1] = smp;
        total = 0;
        for (int i = 0; i < WINDOW_DEF; i++) begin
            total += win_hist[ch][i];
            sorted[i] = win_hist[ch][i];
        end
        // ascending insertion sort
        for (int i = 1; i < WINDOW_DEF; i++) begin
            key = sorted[i];
            j = i;
            while (j > 0 && sorted[j - 1] > key) begin
                sorted[j] = sorted[j - 1];
                j--;
            end
            sorted[j] = key;
        end
        total = total >> MEAN_SHIFT;
        if (total > SAMPLE_MAX)
            total = SAMPLE_MAX;
        r.mean = total[MEAN_FW-1:0];
        mid_sum = sorted[WINDOW_DEF/2 - 1] + sorted[WINDOW_DEF/2];
        r.median = mid_sum[MED_FW:1];
        return r;
    endfunction

    // rising edge: check result transactions first, then record the sample
    // transaction of this edge, whose result can only appear later
    always @(posedge i_clk) begin
        t_window_stats got;
        t_window_stats want;
        if (i_rst_n) begin
            if (o_m_tvalid && m_tready) begin
                got.mean   = o_m_tdata[MEAN_FW-1:0];
                got.median = o_m_tdata[MEAN_FW +: MED_FW];
                if (stats_due.size() == 0) begin
                    flag_mismatch("result transaction with nothing expected");
                end else begin
                    want = stats_due.pop_front();
                    if (got.mean !== want.mean)
                        flag_mismatch($sformatf("window_mean %0d, expected %0d",
                                                got.mean, want.mean));
                    if (got.median !== want.median)
                        flag_mismatch($sformatf("window_median %0d, expected %0d",
                                                got.median, want.median));
                end
                result_count++;
            end
            if (s_tvalid && o_s_tready) begin
                stats_due.push_back(predict_window_stats(s_tuser, s_tdata[SMP_FW-1:0]));
                accept_count++;
            end
        end
    end

    // sample driver: a slot is free when nothing is offered or the offered
    // transaction went through at the last rising edge
    always @(negedge i_clk) begin
        t_sample_item           it;
        logic                   nxt_valid;
        logic [IN_TDATA_W-1:0]  nxt_data;
        logic [IN_TUSER_W-1:0]  nxt_user;
        bit                     slot_free;
        bit                     quiet;
        nxt_valid = s_tvalid;
        nxt_data  = s_tdata;
        nxt_user  = s_tuser;
        quiet     = (accept_count + TAIL_ITEMS >= total_items);
        if (i_rst_n) begin
            slot_free = !s_tvalid || (accept_count != drv_seen);
            drv_seen  = accept_count;
            if (slot_free) begin
                nxt_valid = 1'b0;
                // a drain marker clears only once every result is back
                while (pend_q.size() > 0 && pend_q[0].drain && stats_due.size() == 0)
                    void'(pend_q.pop_front());
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pend_q.size() > 0 && !pend_q[0].drain) begin
                    it        = pend_q.pop_front();
                    nxt_valid = 1'b1;
                    nxt_data  = '0;
                    nxt_data[SMP_FW-1:0] = it.sample;
                    nxt_user  = it.channel;
                    if (!quiet && $urandom_range(0, 4) == 0)
                        send_gap = $urandom_range(1, 12);
                end
            end
        end
        s_tvalid <= nxt_valid;
        s_tdata  <= nxt_data;
        s_tuser  <= nxt_user;
    end

    // result receiver: random stall bursts, none in the tail
    always @(negedge i_clk) begin
        bit quiet;
        quiet = (accept_count + TAIL_ITEMS >= total_items);
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(1, 12) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin
        int ch;
        int smp;
        int base;
        int mode;
        for (int c = 0; c < CHANNELS_DEF; c++)
            for (int i = 0; i < WINDOW_DEF; i++)
                win_hist[c][i] = '0;

        // directed: zero windows, full-scale window, out-of-range channel,
        // alternating bit patterns, lone peak, return toward zero
        add_sample(2, 0);
        for (int i = 0; i < WINDOW_DEF; i++)
            add_sample(0, SAMPLE_MAX);
        add_sample(3, SAMPLE_MAX);
        add_sample(3, 0);
        add_sample(1, 'h2AA);
        add_sample(1, 'h155);
        add_sample(1, SAMPLE_MAX);
        add_sample(1, 1);
        add_sample(2, 512);
        add_sample(0, 0);
        add_sample(0, 0);
        // hold the sender until the directed results are all back
        add_drain();

        // random: mostly real channels, values spread, clustered or at the rails
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == RANDOM_ITEMS / 3 || k == (2 * RANDOM_ITEMS) / 3)
                add_drain();
            ch   = ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, CHANNELS_DEF - 1);
            mode = $urandom_range(0, 9);
            if (mode < 4) begin
                smp = $urandom_range(0, SAMPLE_MAX);
            end else if (mode < 8) begin
                base = (k / 40) * 97 % (SAMPLE_MAX + 1);
                smp  = base + $urandom_range(0, 30) - 15;
                if (smp < 0)
                    smp = 0;
                if (smp > SAMPLE_MAX)
                    smp = SAMPLE_MAX;
            end else begin
                smp = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
            end
            add_sample(ch, smp);
        end

        // reset held at the start, released at a falling edge
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every transaction to go in and every result to come out
        while (pend_q.size() != 0 || s_tvalid || stats_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);

        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
